FILE: hdl/lsct_pkg.sv
// ----------------------------------------------------------------------------
// LRU sheet cache tracker package
// Shared widths, codes and the control state type of the recency tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package lsct_pkg;

    localparam int SHEET_W     = 8;
    localparam int LIST_DEPTH  = 256;
    localparam int COUNT_W     = 9;
    localparam int EVICT_W     = 6;
    localparam int LIMIT_FLOOR = 16;

    localparam logic [1:0] MODE_ACCESS  = 2'd0;
    localparam logic [1:0] MODE_REPORT  = 2'd1;
    localparam logic [1:0] MODE_EVICT   = 2'd2;
    localparam logic [1:0] MODE_UNKNOWN = 2'd3;

    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_DESTROY = 1'b1;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b0_0000_0001,
        S_IDLE   = 9'b0_0000_0010,
        S_LREAD  = 9'b0_0000_0100,
        S_UNLINK = 9'b0_0000_1000,
        S_PUSH1  = 9'b0_0001_0000,
        S_PUSH2  = 9'b0_0010_0000,
        S_EREAD  = 9'b0_0100_0000,
        S_ESTEP  = 9'b0_1000_0000,
        S_STATUS = 9'b1_0000_0000
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/lsct_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lsct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/lru_sheet_cache_tracker.sv
// ----------------------------------------------------------------------------
// LRU sheet cache tracker
// Recency list of sheets in link RAMs; access, texture report and evict.
// ----------------------------------------------------------------------------
// channel   dir  handshake                   contents
// s_axis    in   s_axis_tvalid/tready        request: mode, sheet, flags, count
// m_axis    out  m_axis_tvalid/tready        destroy commands, then one status
// cfg       in   i_cfg_valid/o_cfg_ready     max_entries
//
// Report and invalid requests go straight to status. An evict walks the tail
// through the read and step states; an access reads, unlinks and pushes the
// sheet, then on a miss walks the tail too. The single read port of the link and
// flag RAMs gives each dropped entry a read and a step state. Reset starts a
// pass clearing the member and texture RAMs; input is held off until it ends.
// A stalled output holds the walk at a textured entry; requests go one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_sheet_cache_tracker #(
    parameter int NUM_SHEETS         = 256,
    parameter int MAX_EVICT_PER_ITEM = 63
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // sheet_index[7:0], sheet_ready[8], texture_now[9], evict_count[15:10]
    input  wire  [15:0] s_axis_tdata,
    // mode[1:0]
    input  wire  [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // sheet[7:0], hit[8], create_request[9], invalid[10], evicted[16:11],
    // occupancy[25:17], zero[31:26]
    output logic [31:0] m_axis_tdata,
    // kind[0]
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [8:0]  i_cfg_data
);

    import lsct_pkg::*;

    localparam logic [COUNT_W-1:0] SHEETS_C = COUNT_W'(NUM_SHEETS);
    localparam logic [COUNT_W-1:0] FLOOR_C  = COUNT_W'(LIMIT_FLOOR);
    localparam logic [EVICT_W-1:0] CAP_C    = EVICT_W'(MAX_EVICT_PER_ITEM);

    t_state                 r_state;
    logic [SHEET_W-1:0]     r_head, r_tail, r_idx, r_clr;
    logic [COUNT_W-1:0]     r_total, r_max;
    logic [1:0]             r_mode;
    logic                   r_ready, r_had, r_inv;
    logic [EVICT_W-1:0]     r_target, r_done;

    logic                   nx_we, pv_we;
    logic [SHEET_W-1:0]     nx_waddr, nx_wdata, pv_waddr, pv_wdata, rd_addr;
    logic [SHEET_W-1:0]     nx_rdata, pv_rdata;

    logic                   mb_we, mb_wdata, mb_rdata;
    logic                   tx_we, tx_wdata, tx_rdata;
    logic [SHEET_W-1:0]     mb_waddr, tx_waddr;

    logic [COUNT_W-1:0]     lim, over_acc, over_ev;
    logic                   slot_free, bad_idx, bad_req, step_go, out_load;
    logic [SHEET_W-1:0]     in_idx;
    logic [1:0]             in_mode;

    lsct_ram #(.WIDTH(SHEET_W), .DEPTH(LIST_DEPTH)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_waddr), .i_wdata(nx_wdata),
        .i_raddr(rd_addr), .o_rdata(nx_rdata)
    );

    lsct_ram #(.WIDTH(SHEET_W), .DEPTH(LIST_DEPTH)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_waddr), .i_wdata(pv_wdata),
        .i_raddr(rd_addr), .o_rdata(pv_rdata)
    );

    lsct_ram #(.WIDTH(1), .DEPTH(LIST_DEPTH)) u_member (
        .i_clk(i_clk), .i_we(mb_we), .i_waddr(mb_waddr), .i_wdata(mb_wdata),
        .i_raddr(rd_addr), .o_rdata(mb_rdata)
    );

    lsct_ram #(.WIDTH(1), .DEPTH(LIST_DEPTH)) u_texture (
        .i_clk(i_clk), .i_we(tx_we), .i_waddr(tx_waddr), .i_wdata(tx_wdata),
        .i_raddr(rd_addr), .o_rdata(tx_rdata)
    );

    assign in_idx        = s_axis_tdata[7:0];
    assign in_mode       = s_axis_tuser;
    assign bad_idx       = {1'b0, in_idx} >= SHEETS_C;
    assign bad_req       = in_mode == MODE_UNKNOWN || (in_mode != MODE_EVICT && bad_idx);
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign slot_free     = !m_axis_tvalid || m_axis_tready;
    // an untextured tail entry drops without an output slot
    assign step_go       = !tx_rdata || slot_free;
    assign out_load      = (r_state == S_ESTEP && step_go && tx_rdata)
                         || (r_state == S_STATUS && slot_free);

    always_comb begin
        lim = r_max;
        if (lim < FLOOR_C) lim = FLOOR_C;
        if (lim > SHEETS_C) lim = SHEETS_C;
        // total after the push of an access
        over_acc = (r_total + 1'b1 > lim) ? (r_total + 1'b1 - lim) : '0;
        over_ev  = (r_total > lim) ? (r_total - lim) : '0;
    end

    // link and flag RAM ports
    always_comb begin
        nx_we    = 1'b0;
        pv_we    = 1'b0;
        nx_waddr = r_idx;
        nx_wdata = r_idx;
        pv_waddr = r_idx;
        pv_wdata = r_idx;
        mb_we    = 1'b0;
        mb_waddr = r_idx;
        mb_wdata = 1'b0;
        tx_we    = 1'b0;
        tx_waddr = in_idx;
        tx_wdata = s_axis_tdata[9];
        rd_addr  = (r_state == S_EREAD || r_state == S_ESTEP) ? r_tail : r_idx;
        unique case (r_state)
            S_CLEAR: begin
                mb_we    = 1'b1;
                mb_waddr = r_clr;
                tx_we    = 1'b1;
                tx_waddr = r_clr;
                tx_wdata = 1'b0;
            end
            S_IDLE: begin
                tx_we = s_axis_tvalid && in_mode == MODE_REPORT && !bad_idx;
            end
            S_UNLINK: begin
                if (mb_rdata && r_idx != r_head && r_idx != r_tail) begin
                    nx_we    = 1'b1;
                    nx_waddr = pv_rdata;
                    nx_wdata = nx_rdata;
                    pv_we    = 1'b1;
                    pv_waddr = nx_rdata;
                    pv_wdata = pv_rdata;
                end
            end
            S_PUSH1: begin
                nx_we    = 1'b1;
                nx_wdata = (r_total == '0) ? r_idx : r_head;
                pv_we    = 1'b1;
            end
            S_PUSH2: begin
                mb_we    = 1'b1;
                mb_wdata = 1'b1;
                if (r_total != '0) begin
                    pv_we    = 1'b1;
                    pv_waddr = r_head;
                end
            end
            S_ESTEP: begin
                mb_we    = step_go;
                mb_waddr = r_tail;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_head        <= '0;
            r_tail        <= '0;
            r_total       <= '0;
            r_max         <= COUNT_W'(64);
            m_axis_tvalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end
            if (out_load) begin
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_mode  <= in_mode;
                        r_idx   <= in_idx;
                        r_ready <= s_axis_tdata[8];
                        r_done  <= '0;
                        r_inv   <= bad_req;
                        if (bad_req) begin
                            r_state <= S_STATUS;
                        end else if (in_mode == MODE_REPORT) begin
                            r_state <= S_STATUS;
                        end else if (in_mode == MODE_EVICT) begin
                            if (s_axis_tdata[15:10] != '0) begin
                                r_target <= (s_axis_tdata[15:10] > CAP_C) ? CAP_C
                                                                          : s_axis_tdata[15:10];
                            end else begin
                                r_target <= (over_ev > {3'b0, CAP_C}) ? CAP_C
                                                                      : over_ev[EVICT_W-1:0];
                            end
                            r_state <= S_EREAD;
                        end else begin
                            r_state <= S_LREAD;
                        end
                    end
                end
                S_LREAD: r_state <= S_UNLINK;
                S_UNLINK: begin
                    r_had <= tx_rdata;
                    if (mb_rdata) begin
                        if (r_idx == r_head && r_idx == r_tail) begin
                            // sole entry: list goes empty
                        end else if (r_idx == r_head) begin
                            r_head <= nx_rdata;
                        end else if (r_idx == r_tail) begin
                            r_tail <= pv_rdata;
                        end
                        r_total <= r_total - 1'b1;
                    end
                    r_state <= S_PUSH1;
                end
                S_PUSH1: begin
                    if (r_total == '0) begin
                        r_tail <= r_idx;
                    end
                    r_state <= S_PUSH2;
                end
                S_PUSH2: begin
                    r_head          <= r_idx;
                    r_total         <= r_total + 1'b1;
                    r_target        <= (over_acc > {3'b0, CAP_C}) ? CAP_C
                                                                  : over_acc[EVICT_W-1:0];
                    r_state         <= r_had ? S_STATUS : S_EREAD;
                end
                S_EREAD: begin
                    r_state <= (r_total != '0 && r_done < r_target) ? S_ESTEP : S_STATUS;
                end
                S_ESTEP: begin
                    // hold the walk while a destroy command cannot be placed
                    if (step_go) begin
                        if (r_head != r_tail) begin
                            r_tail <= pv_rdata;
                        end
                        r_total <= r_total - 1'b1;
                        if (tx_rdata) begin
                            r_done        <= r_done + 1'b1;
                            m_axis_tuser  <= KIND_DESTROY;
                            m_axis_tlast  <= 1'b0;
                            m_axis_tdata  <= {6'b0, r_total - 1'b1, r_done + 1'b1,
                                              3'b000, r_tail};
                        end
                        r_state <= S_EREAD;
                    end
                end
                S_STATUS: begin
                    if (slot_free) begin
                        m_axis_tuser  <= KIND_STATUS;
                        m_axis_tlast  <= 1'b1;
                        m_axis_tdata  <= {6'b0, r_total, r_done, r_inv,
                                          r_mode == MODE_ACCESS && !r_inv && !r_had && r_ready,
                                          r_mode == MODE_ACCESS && !r_inv && r_had,
                                          (r_mode[1] && !r_inv) || r_mode == MODE_UNKNOWN
                                              ? {SHEET_W{1'b0}} : r_idx};
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: verif/lru_sheet_cache_tracker_tb.sv
// ----------------------------------------------------------------------------
// LRU sheet cache tracker testbench
// Drives access, texture report and evict requests through the input stream
// and checks every destroy command and status against a recency list model
// kept in the testbench, over several cache limits and idling phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lru_sheet_cache_tracker_tb;
    import lsct_pkg::*;

    localparam int SHEETS   = 256;
    localparam int EVICT_CAP = 63;
    localparam int HOLD_LEN  = 400;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] sheet;
        logic       ready;
        logic       tex;
        logic [5:0] count;
    } req_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] sheet;
        logic       hit;
        logic       create;
        logic       invalid;
        logic [5:0] evicted;
        logic [8:0] occupancy;
        logic       last;
    } rsp_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] in_data;
    logic [1:0]  in_user;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] out_data;
    logic        out_user;
    logic        out_last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [8:0]  cfg_data;

    lru_sheet_cache_tracker dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (in_valid),
        .s_axis_tready (in_ready),
        .s_axis_tdata  (in_data),
        .s_axis_tuser  (in_user),
        .m_axis_tvalid (out_valid),
        .m_axis_tready (out_ready),
        .m_axis_tdata  (out_data),
        .m_axis_tuser  (out_user),
        .m_axis_tlast  (out_last),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    // recency list model
    logic [7:0] nxt [SHEETS];
    logic [7:0] prv [SHEETS];
    bit         member [SHEETS];
    bit         textured [SHEETS];
    bit   [7:0] head, tail;
    int         occ;
    int         limit_reg;

    req_t request_q [$];
    rsp_t expected_q [$];
    int   errors;
    int   send_idle_pct, recv_stall_pct;
    int   hold_cycles;
    int   hold_seq, hold_seen;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #50_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int clamped_limit();
        int v;
        v = limit_reg;
        if (v < LIMIT_FLOOR) v = LIMIT_FLOOR;
        if (v > SHEETS) v = SHEETS;
        return v;
    endfunction

    function automatic void add_result(bit kind, int sheet, bit hit, bit create, bit inv,
                                       int evicted, bit last);
        rsp_t r;
        r.kind = kind;
        r.sheet = sheet[7:0];
        r.hit = hit;
        r.create = create;
        r.invalid = inv;
        r.evicted = evicted[5:0];
        r.occupancy = occ[8:0];
        r.last = last;
        expected_q.insert(expected_q.size(), r);
    endfunction

    function automatic void drop_sheet(logic [7:0] x);
        if (!member[x] || occ == 0) return;
        if (x == head && x == tail) begin
        end else if (x == head) begin
            head = nxt[x];
        end else if (x == tail) begin
            tail = prv[x];
        end else begin
            nxt[prv[x]] = nxt[x];
            prv[nxt[x]] = prv[x];
        end
        member[x] = 0;
        occ--;
    endfunction

    function automatic int evict_from_tail(int target);
        int done;
        logic [7:0] t;
        bit tx;
        done = 0;
        if (target > EVICT_CAP) target = EVICT_CAP;
        while (occ > 0 && done < target) begin
            t = tail;
            tx = textured[t];
            drop_sheet(t);
            if (tx) begin
                done++;
                add_result(KIND_DESTROY, t, 0, 0, 0, done, 0);
            end
        end
        return done;
    endfunction

    function automatic void predict_request(req_t q);
        int done, target;
        bit had, create;
        if (q.mode == MODE_UNKNOWN) begin
            add_result(KIND_STATUS, 0, 0, 0, 1, 0, 1);
        end else if (q.mode == MODE_REPORT) begin
            textured[q.sheet] = q.tex;
            add_result(KIND_STATUS, q.sheet, 0, 0, 0, 0, 1);
        end else if (q.mode == MODE_EVICT) begin
            target = q.count;
            if (q.count == 0) target = occ > clamped_limit() ? occ - clamped_limit() : 0;
            done = evict_from_tail(target);
            add_result(KIND_STATUS, 0, 0, 0, 0, done, 1);
        end else begin
            had = textured[q.sheet];
            create = 0;
            done = 0;
            drop_sheet(q.sheet);
            if (occ == 0) begin
                tail = q.sheet;
                nxt[q.sheet] = q.sheet;
            end else begin
                nxt[q.sheet] = head;
                prv[head] = q.sheet;
            end
            prv[q.sheet] = q.sheet;
            head = q.sheet;
            member[q.sheet] = 1;
            occ++;
            if (!had) begin
                create = q.ready;
                if (occ > clamped_limit()) done = evict_from_tail(occ - clamped_limit());
            end
            add_result(KIND_STATUS, q.sheet, had, create, 0, done, 1);
        end
    endfunction

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                req_t q;
                q = request_q.pop_front();
                predict_request(q);
                in_valid <= 1'b1;
                in_user <= q.mode;
                in_data <= {q.count, q.tex, q.ready, q.sheet};
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver backpressure; a new hold request starts a long hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_cycles <= 0;
            hold_seen <= hold_seq;
        end else if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_cycles <= HOLD_LEN;
            out_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result, sheet", out_data[7:0], 0);
            end else begin
                rsp_t e;
                e = expected_q.pop_front();
                if (out_user != e.kind) report_mismatch("kind", out_user, e.kind);
                if (out_data[7:0] != e.sheet) report_mismatch("sheet", out_data[7:0], e.sheet);
                if (out_data[8] != e.hit) report_mismatch("hit", out_data[8], e.hit);
                if (out_data[9] != e.create) report_mismatch("create", out_data[9], e.create);
                if (out_data[10] != e.invalid)
                    report_mismatch("invalid", out_data[10], e.invalid);
                if (out_data[16:11] != e.evicted)
                    report_mismatch("evicted", out_data[16:11], e.evicted);
                if (out_data[25:17] != e.occupancy)
                    report_mismatch("occupancy", out_data[25:17], e.occupancy);
                if (out_data[31:26] != 6'd0) report_mismatch("pad", out_data[31:26], 0);
                if (out_last != e.last) report_mismatch("last", out_last, e.last);
            end
        end
    end

    task automatic queue_request(logic [1:0] mode, int sheet, bit ready, bit tex, int count);
        req_t q;
        q.mode = mode;
        q.sheet = sheet[7:0];
        q.ready = ready;
        q.tex = tex;
        q.count = count[5:0];
        request_q.insert(request_q.size(), q);
    endtask

    // wait until everything sent has come back, then let the walk settle
    task automatic drain();
        int n;
        n = 0;
        while ((request_q.size() > 0 || in_valid || expected_q.size() > 0) && n < 2_000_000) begin
            @(posedge clk);
            n++;
        end
        repeat (600) @(posedge clk);
    endtask

    task automatic write_limit(int value);
        cfg_valid <= 1'b1;
        cfg_data <= value[8:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        limit_reg = value;
    endtask

    // mostly accesses over a sheet pool, with reports, evicts and unknown modes mixed in
    task automatic queue_random(int n, int pool);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 55)
                queue_request(MODE_ACCESS, int'($urandom_range(pool - 1)),
                              1'($urandom_range(1)), 0, 0);
            else if (r < 85)
                queue_request(MODE_REPORT, int'($urandom_range(pool - 1)), 0,
                              $urandom_range(3) != 0, 0);
            else if (r < 95)
                queue_request(MODE_EVICT, int'($urandom()), 1'($urandom_range(1)),
                              1'($urandom_range(1)),
                              $urandom_range(3) == 0 ? 0 : int'($urandom_range(63)));
            else
                queue_request(MODE_UNKNOWN, int'($urandom()), 1'($urandom_range(1)),
                              1'($urandom_range(1)), int'($urandom_range(63)));
        end
    endtask

    initial begin
        limit_reg = 64;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: smallest limit, misses, hits, reports, evicts, bad modes
        write_limit(0);
        queue_request(MODE_EVICT, 0, 0, 0, 0);
        queue_request(MODE_EVICT, 0, 0, 0, 5);
        queue_request(MODE_ACCESS, 0, 1, 0, 0);
        queue_request(MODE_ACCESS, 255, 0, 1, 63);
        queue_request(MODE_REPORT, 0, 1, 1, 0);
        queue_request(MODE_REPORT, 255, 0, 1, 0);
        queue_request(MODE_ACCESS, 0, 1, 0, 0);
        queue_request(MODE_ACCESS, 255, 1, 0, 0);
        queue_request(MODE_UNKNOWN, 170, 1, 1, 42);
        for (int s = 1; s <= 18; s++) queue_request(MODE_REPORT, s, 0, 1, 0);
        for (int s = 1; s <= 18; s++) queue_request(MODE_ACCESS, s, 1'(s % 2), 0, 0);
        queue_request(MODE_REPORT, 255, 0, 0, 0);
        queue_request(MODE_EVICT, 0, 0, 0, 63);
        drain();

        // no idling
        write_limit(20);
        queue_random(40, 40);
        drain();

        // sender idle; receiver held off long while the sender keeps going
        write_limit(256);
        send_idle_pct = 60;
        queue_random(30, 256);
        hold_seq++;
        drain();

        // receiver stalls, including evicts of textured entries at the full per-request cap
        write_limit(511);
        send_idle_pct = 0;
        recv_stall_pct = 60;
        for (int s = 0; s < 70; s++) queue_request(MODE_REPORT, s, 0, 1, 0);
        for (int s = 0; s < 70; s++) queue_request(MODE_ACCESS, s, 1, 0, 0);
        queue_request(MODE_EVICT, 0, 0, 0, 63);
        queue_request(MODE_EVICT, 0, 0, 0, 63);
        drain();

        // both sides idling
        write_limit(16);
        send_idle_pct = 16;
        recv_stall_pct = 16;
        queue_random(50, 48);
        drain();

        write_limit(100);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_random(20, 160);
        drain();

        if (errors == 0 && expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
